>>> design/assert_macros.svh
// assertion macros used by the top-level design file
// no dependencies; users supply clock and reset in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under reset
`define JTG_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication under reset
`define JTG_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/jtg_pkg.sv
// shared types and constants of the joint trajectory generator
// no dependencies
package jtg_pkg;

   localparam int T_WIDTH   = 16;
   localparam int S_WIDTH   = 17;
   localparam int DUR_WIDTH = 16;
   localparam int PCT_WIDTH = 7;

   localparam logic [2:0] CMD_LOAD  = 3'd0;
   localparam logic [2:0] CMD_START = 3'd1;
   localparam logic [2:0] CMD_STOP  = 3'd2;
   localparam logic [2:0] CMD_RESET = 3'd3;
   localparam logic [2:0] CMD_TICK  = 3'd4;

   localparam logic [1:0] CSR_PROFILE_MODE = 2'd0;
   localparam logic [1:0] CSR_DURATION     = 2'd1;
   localparam logic [1:0] CSR_JOINT_COUNT  = 2'd2;

   localparam logic [1:0] PROF_LINEAR = 2'd0;
   localparam logic [1:0] PROF_CUBIC  = 2'd1;

   localparam logic [DUR_WIDTH-1:0] MIN_DURATION = 16'd10;
   localparam logic [PCT_WIDTH-1:0] PCT_FULL     = 7'd100;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_PROF1,
      ST_PROF2,
      ST_PROF3,
      ST_READ,
      ST_MUL,
      ST_EMIT
   } state_type;

endpackage

>>> design/jtg_div.sv
// serial restoring divider, one quotient bit per cycle
// forms floor(dividend * 2^16 / divisor) for dividend below divisor; uses jtg_pkg
module jtg_div import jtg_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [T_WIDTH:0]     dividend,
   input  logic [DUR_WIDTH-1:0] divisor,
   output logic                 done,
   output logic [T_WIDTH-1:0]   quotient
);

   localparam int CNT_W = $clog2(T_WIDTH + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [T_WIDTH:0]     rem_ff, rem_in;
   logic [T_WIDTH-1:0]   quo_ff, quo_in;
   logic [DUR_WIDTH-1:0] dsr_ff, dsr_in;
   logic [T_WIDTH+1:0]   shifted;
   logic                 ge;

   always_comb begin
      shifted = {rem_ff, 1'b0};
      ge      = shifted >= (T_WIDTH + 2)'(dsr_ff);
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? (T_WIDTH + 1)'(shifted - (T_WIDTH + 2)'(dsr_ff))
                     : shifted[T_WIDTH:0];
         quo_in = {quo_ff[T_WIDTH-2:0], ge};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(T_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> design/joint_trajectory_generator.sv
// joint trajectory generator top level: command decode, profile math, joint table
// depends on jtg_pkg, jtg_div and assert_macros.svh
// Load, start and stop beats are taken in the idle state and leave it there. A reset beat
// or a tick that ends the motion steps through a read, a multiply and an emit per joint in
// use. An interpolating tick first runs the serial divider (one quotient bit a cycle),
// then three profile steps, then per joint one read of the joint table, a multiply
// and an emit. Result beats wait in an output register, so a stalled result slows
// only the joint loop. The joint table needs no clearing pass.
`include "assert_macros.svh"

module joint_trajectory_generator import jtg_pkg::*; #(
   parameter int JOINTS    = 8,
   parameter int POS_WIDTH = 24
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [2:0]                  req_cmd,
   input  logic [2:0]                  req_joint_sel,
   input  logic signed [POS_WIDTH-1:0] req_start_value,
   input  logic signed [POS_WIDTH-1:0] req_end_value,
   input  logic [15:0]                 req_elapsed_ms,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [2:0]                  rsp_joint_out,
   output logic signed [POS_WIDTH-1:0] rsp_joint_position,
   output logic [PCT_WIDTH-1:0]        rsp_progress_pct,
   output logic                        rsp_finished,
   output logic                        rsp_last_joint,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [1:0]                  csr_index,
   input  logic [15:0]                 csr_data
);

   localparam int JW     = (JOINTS > 1) ? $clog2(JOINTS) : 1;
   localparam int DIFF_W = POS_WIDTH + 1;
   localparam int PROD_W = S_WIDTH + 1 + DIFF_W;
   localparam int NUM_W  = PROD_W + 1;

   function automatic logic [JW-1:0] wrap_sel(input logic [2:0] sel);
      logic [4:0] v;
      v = {2'b00, sel};
      for (int k = 0; k < 8; k++) begin
         if (v >= 5'(JOINTS)) v = v - 5'(JOINTS);
      end
      return JW'(v);
   endfunction

   state_type state_ff, state_in;

   logic [1:0]           mode_ff;
   logic [DUR_WIDTH-1:0] dur_ff;
   logic [3:0]           count_ff;
   logic [T_WIDTH-1:0]   elapsed_ff;
   logic                 running_ff;

   logic [2*POS_WIDTH-1:0] mem [JOINTS];
   logic [2*POS_WIDTH-1:0] rd_data_ff;

   logic [JW-1:0]         jidx_ff;
   logic [T_WIDTH-1:0]    t_ff;
   logic [2*T_WIDTH-1:0]  t2_ff;
   logic [2*T_WIDTH-1:0]  t3_ff;
   logic [20:0]           fac_ff;
   logic [S_WIDTH-1:0]    s_ff;
   logic [PCT_WIDTH-1:0]  pct_ff;
   logic                  fin_ff;
   logic                  use_end_ff;
   logic signed [PROD_W-1:0]    prod_ff;
   logic signed [POS_WIDTH-1:0] a_ff;
   logic signed [POS_WIDTH-1:0] b_ff;

   logic                        rsp_valid_ff;
   logic [2:0]                  rsp_joint_ff;
   logic signed [POS_WIDTH-1:0] rsp_pos_ff;
   logic [PCT_WIDTH-1:0]        rsp_pct_ff;
   logic                        rsp_fin_ff;
   logic                        rsp_last_ff;

   logic                 accept, tick_run, tick_end, tick_div, out_free, emit_go, is_last;
   logic [DUR_WIDTH-1:0] dur_eff;
   logic [4:0]           n_eff;
   logic [T_WIDTH:0]     sum;
   logic                 div_done;
   logic [T_WIDTH-1:0]   div_q;

   logic [22:0]          pct_prod;
   logic [17:0]          c_fac;
   logic [49:0]          cub_prod;
   logic [47:0]          t3_prod;
   logic [36:0]          inner_sum;
   logic [52:0]          quin_prod;
   logic signed [POS_WIDTH-1:0] mem_a, mem_b;
   logic signed [DIFF_W-1:0]    diff;
   logic signed [NUM_W-1:0]     num, shr;
   logic signed [POS_WIDTH-1:0] pos;

   assign accept    = req_valid && req_ready;
   assign dur_eff   = (dur_ff < MIN_DURATION) ? MIN_DURATION : dur_ff;
   assign n_eff     = (count_ff == 4'd0) ? 5'd1
                    : (5'(count_ff) > 5'(JOINTS)) ? 5'(JOINTS) : 5'(count_ff);
   assign sum       = (T_WIDTH + 1)'(elapsed_ff) + (T_WIDTH + 1)'(req_elapsed_ms);
   assign tick_run  = accept && (req_cmd == CMD_TICK) && running_ff;
   assign tick_end  = tick_run && (sum >= (T_WIDTH + 1)'(dur_eff));
   assign tick_div  = tick_run && !tick_end;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign emit_go   = (state_ff == ST_EMIT) && out_free;
   assign is_last   = (5'(jidx_ff) + 5'd1) == n_eff;

   jtg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (tick_div),
      .dividend (sum),
      .divisor  (dur_eff),
      .done     (div_done),
      .quotient (div_q)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_cmd == CMD_RESET)) state_in = ST_READ;
            else if (tick_end) state_in = ST_READ;
            else if (tick_div) state_in = ST_DIV;
         end
         ST_DIV:   if (div_done) state_in = ST_PROF1;
         ST_PROF1: state_in = ST_PROF2;
         ST_PROF2: state_in = ST_PROF3;
         ST_PROF3: state_in = ST_READ;
         ST_READ:  state_in = ST_MUL;
         ST_MUL:   state_in = ST_EMIT;
         ST_EMIT:  if (out_free) state_in = is_last ? ST_IDLE : ST_READ;
         default:  state_in = ST_IDLE;
      endcase
   end

   // datapath arithmetic
   always_comb begin
      pct_prod  = 23'(t_ff) * 23'd100;
      c_fac     = 18'd196608 - {1'b0, t_ff, 1'b0};
      cub_prod  = 50'(t2_ff) * 50'(c_fac);
      t3_prod   = 48'(t2_ff) * 48'(t_ff);
      inner_sum = (37'd10 << 32) - 37'(t_ff) * 37'd983040 + 37'(t2_ff) * 37'd6;
      quin_prod = 53'(t3_ff) * 53'(fac_ff);
      mem_a     = rd_data_ff[POS_WIDTH-1:0];
      mem_b     = rd_data_ff[2*POS_WIDTH-1:POS_WIDTH];
      diff      = DIFF_W'(mem_b) - DIFF_W'(mem_a);
      num       = (NUM_W'(a_ff) <<< 16) + NUM_W'(prod_ff);
      shr       = num >>> 16;
      if (num[NUM_W-1] && (num[15:0] != 16'd0)) shr = shr + NUM_W'(1);
      pos       = use_end_ff ? b_ff : shr[POS_WIDTH-1:0];
   end

   // joint table
   always_ff @(posedge clock) begin
      if (accept && (req_cmd == CMD_LOAD)) begin
         mem[wrap_sel(req_joint_sel)] <= {req_end_value, req_start_value};
      end
      rd_data_ff <= mem[jidx_ff];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= 2'd2;
         dur_ff       <= 16'd3000;
         count_ff     <= 4'd6;
         elapsed_ff   <= '0;
         running_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         jidx_ff      <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            priority case (csr_index)
               CSR_PROFILE_MODE: mode_ff  <= csr_data[1:0];
               CSR_DURATION:     dur_ff   <= csr_data;
               CSR_JOINT_COUNT:  count_ff <= csr_data[3:0];
               default: ;
            endcase
         end
         if (accept) begin
            priority case (req_cmd)
               CMD_LOAD:  elapsed_ff <= '0;
               CMD_START: running_ff <= 1'b1;
               CMD_STOP:  running_ff <= 1'b0;
               CMD_RESET: begin
                  running_ff <= 1'b0;
                  elapsed_ff <= '0;
               end
               CMD_TICK: begin
                  if (tick_end) begin
                     elapsed_ff <= dur_eff;
                     running_ff <= 1'b0;
                  end else if (tick_div) begin
                     elapsed_ff <= sum[T_WIDTH-1:0];
                  end
               end
               default: ;
            endcase
         end
         if (accept) jidx_ff <= '0;
         else if (emit_go && !is_last) jidx_ff <= jidx_ff + JW'(1);
         if (emit_go) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s_ff       <= '0;
         pct_ff     <= tick_end ? PCT_FULL : '0;
         fin_ff     <= tick_end;
         use_end_ff <= tick_end;
      end
      if (div_done) t_ff <= div_q;
      if (state_ff == ST_PROF1) begin
         t2_ff  <= (2*T_WIDTH)'(t_ff) * (2*T_WIDTH)'(t_ff);
         pct_ff <= pct_prod[22:16];
      end
      if (state_ff == ST_PROF2) begin
         t3_ff  <= t3_prod[47:16];
         fac_ff <= inner_sum[36:16];
         if (mode_ff == PROF_LINEAR) s_ff <= S_WIDTH'(t_ff);
         else s_ff <= cub_prod[48:32];
      end
      if ((state_ff == ST_PROF3) && (mode_ff != PROF_LINEAR) && (mode_ff != PROF_CUBIC)) begin
         s_ff <= quin_prod[48:32];
      end
      if (state_ff == ST_MUL) begin
         prod_ff <= PROD_W'($signed({1'b0, s_ff})) * PROD_W'(diff);
         a_ff    <= mem_a;
         b_ff    <= mem_b;
      end
      if (emit_go) begin
         rsp_joint_ff <= 3'(jidx_ff);
         rsp_pos_ff   <= pos;
         rsp_pct_ff   <= pct_ff;
         rsp_fin_ff   <= fin_ff;
         rsp_last_ff  <= is_last;
      end
   end

   assign req_ready          = (state_ff == ST_IDLE);
   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_joint_out      = rsp_joint_ff;
   assign rsp_joint_position = rsp_pos_ff;
   assign rsp_progress_pct   = rsp_pct_ff;
   assign rsp_finished       = rsp_fin_ff;
   assign rsp_last_joint     = rsp_last_ff;

   `JTG_ASSERT_IMPLY(a_fin_full, rsp_valid && rsp_finished, rsp_progress_pct == PCT_FULL, "finished beat without full progress")
   `JTG_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_joint_position), "stalled beat not held")
   `JTG_ASSERT_IMPLY(a_part_pct, rsp_valid && !rsp_finished, rsp_progress_pct < PCT_FULL, "unfinished beat at full progress")
   `JTG_ASSERT_NEXT(a_div_prof, (state_ff == ST_DIV) && div_done, state_ff == ST_PROF1, "divider result not taken")

endmodule
